FILE: hw/rtl/tcs_pkg.sv
// Shared types and constants for the throttle curve shaper.
// Holds the sample type, fixed-point constants, mode and register codes,
// and the exp2 root table. No dependencies.
package tcs_pkg;

    typedef logic signed [15:0] t_sample;

    localparam logic [14:0] ONE_Q14   = 15'd16384;
    localparam logic [30:0] ONE_Q30   = 31'd1073741824;
    localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
    localparam logic [15:0] E_ONE     = 16'd4096;
    localparam logic [29:0] DEN_ONE   = 30'd67108864;

    typedef enum logic [2:0] {
        MODE_EXP     = 3'd0,
        MODE_EXP_NAT = 3'd1,
        MODE_NAT     = 3'd2,
        MODE_POLY    = 3'd3,
        MODE_LIN     = 3'd4
    } t_mode;

    localparam logic [1:0] REG_ACCEL = 2'd0;
    localparam logic [1:0] REG_BRAKE = 2'd1;
    localparam logic [1:0] REG_MODE  = 2'd2;

    // Root 2^(2^-(idx+1)) in Q30.
    function automatic logic [30:0] root_q30(input logic [3:0] idx);
        logic [30:0] v_r;
        unique case (idx)
            4'd0:  v_r = 31'd1518500250;
            4'd1:  v_r = 31'd1276901417;
            4'd2:  v_r = 31'd1170923762;
            4'd3:  v_r = 31'd1121280436;
            4'd4:  v_r = 31'd1097253708;
            4'd5:  v_r = 31'd1085434106;
            4'd6:  v_r = 31'd1079572136;
            4'd7:  v_r = 31'd1076653033;
            4'd8:  v_r = 31'd1075196443;
            4'd9:  v_r = 31'd1074468888;
            4'd10: v_r = 31'd1074105294;
            4'd11: v_r = 31'd1073923544;
            4'd12: v_r = 31'd1073832680;
            4'd13: v_r = 31'd1073787251;
            4'd14: v_r = 31'd1073764537;
            default: v_r = 31'd1073753181;
        endcase
        return v_r;
    endfunction

endpackage

FILE: hw/rtl/tcs_req_if.sv
// Request channel carrying one throttle sample.
// Depends on tcs_pkg for the sample type.
interface tcs_req_if;
    logic             valid;
    logic             ready;
    tcs_pkg::t_sample throttle_in;

    modport source (output valid, output throttle_in, input ready);
    modport sink (input valid, input throttle_in, output ready);
endinterface

FILE: hw/rtl/tcs_rsp_if.sv
// Result channel carrying one shaped throttle value.
// Depends on tcs_pkg for the sample type.
interface tcs_rsp_if;
    logic             valid;
    logic             ready;
    tcs_pkg::t_sample throttle_out;

    modport source (output valid, output throttle_out, input ready);
    modport sink (input valid, input throttle_out, output ready);
endinterface

FILE: hw/rtl/throttle_curve_shaper_core.sv
// Throttle curve shaper: pipelined log2/exp2 and divider datapath.
// Depends on tcs_pkg, tcs_req_if and tcs_rsp_if.
//
// Channel   Dir  Payload              Format
// i_req     in   throttle_in          signed Q2.14
// o_rsp     out  throttle_out         signed Q2.14
// i_cfg_*   in   accel, brake, mode   write only, index 0..2
//
// One request is taken per cycle while no result is held at the output; each result
// passes through 38 register stages, set mostly by the 16-step
// squaring log2 chain and the 16-step exp2 root chain, each step one stage.
// Reset clears the valid bits and loads the default registers.
// While a result is held at the output the whole pipeline holds.
module throttle_curve_shaper_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tcs_req_if.sink     i_req,
    tcs_rsp_if.source   o_rsp,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    localparam int NS = 38;

    typedef struct packed {
        logic        neg;
        logic        pos;
        logic        kz;
        logic [14:0] x;
        logic [15:0] k;
        logic [14:0] b;
        logic [15:0] e;
        logic [30:0] lg_m;
        logic [3:0]  lg_p;
        logic [15:0] lg_fr;
        logic [23:0] pw_n;
        logic [15:0] pw_f;
        logic [8:0]  pw_sh;
        logic [30:0] pw_r;
        logic [30:0] at;
        logic [30:0] ak;
        logic [21:0] ny_n;
        logic [21:0] ny_d;
        logic [30:0] en_r;
        logic [30:0] ed_r;
        logic [50:0] num;
        logic [50:0] den;
        logic [64:0] nrem;
        logic [14:0] nq;
        logic        novf;
        logic [29:0] pden;
        logic [40:0] prem;
        logic [14:0] pq;
        logic [14:0] ex;
        logic [14:0] na;
        logic [14:0] po;
        logic [15:0] out;
    } t_stage;

    logic signed [15:0] r_accel;
    logic signed [15:0] r_brake;
    logic [2:0]         r_curve_mode;

    t_stage      r_st [NS];
    t_stage      n_st [NS];
    logic [NS-1:0] r_vld;
    logic        w_en;

    localparam logic [2:0] MODE_LIN_C = tcs_pkg::MODE_LIN;

    assign w_en         = !r_vld[NS-1] || o_rsp.ready;
    assign i_req.ready  = w_en;
    assign o_rsp.valid  = r_vld[NS-1];
    assign o_rsp.throttle_out = r_st[NS-1].out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel      <= '0;
            r_brake      <= '0;
            r_curve_mode <= MODE_LIN_C;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == tcs_pkg::REG_ACCEL) begin
                r_accel <= i_cfg_data;
            end else if (i_cfg_idx == tcs_pkg::REG_BRAKE) begin
                r_brake <= i_cfg_data;
            end else if (i_cfg_idx == tcs_pkg::REG_MODE) begin
                r_curve_mode <= i_cfg_data[2:0];
            end
        end
    end

    // Entry stage: clamp, magnitude and curve select.
    always_comb begin
        tcs_pkg::t_sample   v_in;
        logic signed [15:0] v_c;
        n_st[0]     = '0;
        v_in        = i_req.throttle_in;
        n_st[0].neg = v_in[15];
        if (v_in < -16'sd16384) begin
            n_st[0].x = tcs_pkg::ONE_Q14;
        end else if (v_in > 16'sd16384) begin
            n_st[0].x = tcs_pkg::ONE_Q14;
        end else if (v_in[15]) begin
            n_st[0].x = 15'(16'd0 - 16'(v_in));
        end else begin
            n_st[0].x = v_in[14:0];
        end
        v_c         = v_in[15] ? r_brake : r_accel;
        n_st[0].pos = !v_c[15];
        n_st[0].k   = v_c[15] ? 16'(16'd0 - 16'(v_c)) : 16'(v_c);
    end

    for (genvar s = 1; s < NS; s++) begin : g_st
        localparam int JN = (s >= 3 && s <= 18) ? s - 2 : 1;
        localparam int JP = (s >= 20 && s <= 35) ? s - 19 : 1;
        localparam int DB = (s >= 21 && s <= 35) ? 35 - s : 0;

        always_comb begin
            t_stage      v_r;
            logic [14:0] v_b;
            logic [3:0]  v_p;
            logic [61:0] v_sq;
            logic [31:0] v_s;
            logic [19:0] v_l;
            logic [4:0]  v_shn;
            logic [4:0]  v_shd;
            logic [65:0] v_dsh;
            logic [44:0] v_psh;
            logic [30:0] v_pr;
            logic [15:0] v_rd;
            logic [14:0] v_pow;
            logic [14:0] v_nat;
            logic [15:0] v_sum;
            logic [14:0] v_ret;

            v_r   = r_st[s-1];
            v_b   = '0;
            v_p   = '0;
            v_sq  = '0;
            v_s   = '0;
            v_l   = '0;
            v_shn = '0;
            v_shd = '0;
            v_dsh = '0;
            v_psh = '0;
            v_pr  = '0;
            v_rd  = '0;
            v_pow = '0;
            v_nat = '0;
            v_sum = '0;
            v_ret = '0;

            if (s == 1) begin
                v_b = v_r.pos ? 15'(tcs_pkg::ONE_Q14 - v_r.x) : v_r.x;
                for (int i = 0; i < 15; i++) begin
                    if (v_b[i]) begin
                        v_p = 4'(i);
                    end
                end
                v_r.b     = v_b;
                v_r.kz    = (v_r.k == 16'd0);
                v_r.e     = tcs_pkg::E_ONE + v_r.k;
                v_r.lg_p  = v_p;
                v_r.lg_m  = 31'(v_b) << (5'd30 - 5'(v_p));
                v_r.lg_fr = '0;
                v_r.at    = 31'(v_r.k) * 31'(v_b);
                v_r.ak    = 31'({v_r.k, 14'b0});
                v_r.pden  = tcs_pkg::DEN_ONE
                          + 30'(v_r.k) * 30'(tcs_pkg::ONE_Q14 - v_b);
            end

            if (s >= 2 && s <= 17) begin
                v_sq = 62'(v_r.lg_m) * 62'(v_r.lg_m);
                v_s  = v_sq[61:30];
                if (v_s[31]) begin
                    v_r.lg_m  = v_s[31:1];
                    v_r.lg_fr = {v_r.lg_fr[14:0], 1'b1};
                end else begin
                    v_r.lg_m  = v_s[30:0];
                    v_r.lg_fr = {v_r.lg_fr[14:0], 1'b0};
                end
            end

            if (s == 2) begin
                v_r.ny_n = 22'((62'(v_r.at) * 62'(tcs_pkg::LOG2E_Q30)) >> 40);
                v_r.ny_d = 22'((62'(v_r.ak) * 62'(tcs_pkg::LOG2E_Q30)) >> 40);
                v_r.en_r = tcs_pkg::ONE_Q30;
                v_r.ed_r = tcs_pkg::ONE_Q30;
            end

            if (s >= 3 && s <= 18) begin
                if (v_r.ny_n[16-JN]) begin
                    v_r.en_r = 31'((62'(v_r.en_r)
                             * 62'(tcs_pkg::root_q30(4'(JN - 1)))) >> 30);
                end
                if (v_r.ny_d[16-JN]) begin
                    v_r.ed_r = 31'((62'(v_r.ed_r)
                             * 62'(tcs_pkg::root_q30(4'(JN - 1)))) >> 30);
                end
            end

            if (s == 18) begin
                v_l      = {4'(4'd14 - v_r.lg_p), 16'b0} - 20'(v_r.lg_fr);
                v_r.pw_n = 24'((36'(v_l) * 36'(v_r.e)) >> 12);
            end

            if (s == 19) begin
                v_r.pw_f  = 16'd0 - v_r.pw_n[15:0];
                v_r.pw_sh = 9'((25'(v_r.pw_n) + 25'd65535) >> 16);
                v_r.pw_r  = tcs_pkg::ONE_Q30;
                v_shn     = (v_r.ny_n[21:16] > 6'd20) ? 5'd20 : v_r.ny_n[20:16];
                v_shd     = (v_r.ny_d[21:16] > 6'd20) ? 5'd20 : v_r.ny_d[20:16];
                v_r.num   = (51'(v_r.en_r) << v_shn) - 51'(tcs_pkg::ONE_Q30);
                v_r.den   = (51'(v_r.ed_r) << v_shd) - 51'(tcs_pkg::ONE_Q30);
            end

            if (s >= 20 && s <= 35) begin
                if (v_r.pw_f[16-JP]) begin
                    v_r.pw_r = 31'((62'(v_r.pw_r)
                             * 62'(tcs_pkg::root_q30(4'(JP - 1)))) >> 30);
                end
            end

            if (s == 20) begin
                v_r.nrem = {v_r.num, 14'b0};
                v_r.novf = ({1'b0, v_r.num} >= {v_r.den, 1'b0});
                v_r.nq   = '0;
                v_r.prem = {v_r.b, 26'b0};
                v_r.pq   = '0;
            end

            if (s >= 21 && s <= 35) begin
                v_dsh = 66'(v_r.den) << DB;
                if (66'(v_r.nrem) >= v_dsh) begin
                    v_r.nrem   = 65'(66'(v_r.nrem) - v_dsh);
                    v_r.nq[DB] = 1'b1;
                end
                v_psh = 45'(v_r.pden) << DB;
                if (45'(v_r.prem) >= v_psh) begin
                    v_r.prem   = 41'(45'(v_r.prem) - v_psh);
                    v_r.pq[DB] = 1'b1;
                end
            end

            if (s == 36) begin
                v_pr = v_r.pw_r >> v_r.pw_sh;
                v_rd = 16'((32'(v_pr) + 32'd32768) >> 16);
                if (v_r.b == 15'd0) begin
                    v_pow = '0;
                end else if (v_r.kz) begin
                    v_pow = v_r.b;
                end else if (v_rd > 16'(tcs_pkg::ONE_Q14)) begin
                    v_pow = tcs_pkg::ONE_Q14;
                end else begin
                    v_pow = v_rd[14:0];
                end
                v_r.ex = v_r.pos ? 15'(tcs_pkg::ONE_Q14 - v_pow) : v_pow;

                if (v_r.kz || v_r.den == 51'd0) begin
                    v_nat = v_r.b;
                end else if (v_r.novf || v_r.nq > tcs_pkg::ONE_Q14) begin
                    v_nat = tcs_pkg::ONE_Q14;
                end else begin
                    v_nat = v_r.nq;
                end
                v_r.na = v_r.pos ? 15'(tcs_pkg::ONE_Q14 - v_nat) : v_nat;
                v_r.po = v_r.pos ? 15'(tcs_pkg::ONE_Q14 - v_r.pq) : v_r.pq;
            end

            if (s == 37) begin
                v_sum = 16'(v_r.ex) + 16'(v_r.na);
                unique case (r_curve_mode)
                    tcs_pkg::MODE_EXP:     v_ret = v_r.ex;
                    tcs_pkg::MODE_EXP_NAT: v_ret = v_sum[15:1];
                    tcs_pkg::MODE_NAT:     v_ret = v_r.na;
                    tcs_pkg::MODE_POLY:    v_ret = v_r.po;
                    default:               v_ret = v_r.x;
                endcase
                if (v_ret > tcs_pkg::ONE_Q14) begin
                    v_ret = tcs_pkg::ONE_Q14;
                end
                v_r.out = v_r.neg ? 16'(16'd0 - 16'(v_ret)) : 16'(v_ret);
            end

            n_st[s] = v_r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NS-2:0], i_req.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int s = 0; s < NS; s++) begin
                r_st[s] <= n_st[s];
            end
        end
    end

endmodule
